[src/shortest_path_dijkstra_assert.svh]
// assertion macros for the shortest path block
`ifndef SHORTEST_PATH_DIJKSTRA_ASSERT_SVH
`define SHORTEST_PATH_DIJKSTRA_ASSERT_SVH
`ifndef SYNTH
`define SPD_ASSERT_ALWAYS(lbl, expr) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (expr)) else $error("shortest path assertion failed");
`define SPD_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (ante) |=> (cons)) else $error("shortest path assertion failed");
`else
`define SPD_ASSERT_ALWAYS(lbl, expr)
`define SPD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/spd_pkg.sv]
`default_nettype none
package spd_pkg;

  localparam int OP_W   = 2;
  localparam int VTX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int WIN_W  = 16;
  localparam int DIST_W = 20;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [VTX_W-1:0]  vtx_t;
  typedef logic [OP_W-1:0]   op_t;

  localparam dist_t DIST_MAX = 20'hFFFFF;

  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_ONE   = 2'd1;
  localparam op_t OP_ALL   = 2'd2;

  // result of one relaxation step
  typedef struct packed {
    logic  upd;
    dist_t new_dist;
  } relax_t;

endpackage
`default_nettype wire

[src/spd_ram.sv]
`default_nettype none
module spd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[src/spd_relax.sv]
`default_nettype none
module spd_relax import spd_pkg::*; #(
  parameter int WEIGHT_BITS = 16
) (
  input  wire dist_t                  base_dist,
  input  wire logic [WEIGHT_BITS-1:0] weight,
  input  wire dist_t                  old_dist,
  input  wire logic                   old_reached,
  output relax_t                      res
);

  localparam int SW = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  logic [SW-1:0] sum;
  dist_t         cand;

  always_comb begin
    sum  = SW'(base_dist) + SW'(weight);
    // path sums saturate at the top of the distance range
    cand = (sum > SW'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
    res.new_dist = cand;
    res.upd      = (weight != '0) && (!old_reached || (cand < old_dist));
  end

endmodule
`default_nettype wire

[src/shortest_path_dijkstra.sv]
// edge write: the item passes the decode and response states, then its result is registered
// query: each settle round scans n distances then relaxes one row of n weights,
//   up to n rounds, then each result is read in a read state and loaded in a load state
//   that waits for a free output slot; the one read port of each memory sets the pace
// one item at a time; the next item is taken while a result waits in the output register
// reset: the edge memory is cleared one entry a cycle, all 2**(2*clog2(MAX_VERTICES)) entries
`default_nettype none
`include "shortest_path_dijkstra_assert.svh"
module shortest_path_dijkstra import spd_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_write_en,
  input  wire logic [CNT_W-1:0] cfg_write_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire op_t              in_operation,
  input  wire vtx_t             in_from_vertex,
  input  wire vtx_t             in_to_vertex,
  input  wire logic [WIN_W-1:0] in_edge_weight,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_status,
  output vtx_t                  out_vertex,
  output dist_t                 out_distance,
  output logic                  out_reachable,
  output logic                  out_last
);

  localparam int VB     = $clog2(MAX_VERTICES);
  localparam int EAW    = 2 * VB;
  localparam int EDEPTH = 1 << EAW;
  localparam int CAP    = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DECODE = 4'd2;
  localparam logic [3:0] ST_RESP   = 4'd3;
  localparam logic [3:0] ST_INIT   = 4'd4;
  localparam logic [3:0] ST_SCAN   = 4'd5;
  localparam logic [3:0] ST_RELAX  = 4'd6;
  localparam logic [3:0] ST_OUTRD  = 4'd7;
  localparam logic [3:0] ST_OUTLD  = 4'd8;

  logic [3:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        vc_r, vc_nxt;
  op_t                     op_r, op_nxt;
  vtx_t                    from_r, from_nxt;
  vtx_t                    to_r, to_nxt;
  logic [WIN_W-1:0]        wt_r, wt_nxt;
  logic                    err_r, err_nxt;
  vtx_t                    idx_r, idx_nxt;
  logic                    iss_done_r, iss_done_nxt;
  logic                    p_vld_r, p_vld_nxt;
  vtx_t                    p_idx_r, p_idx_nxt;
  logic                    p_last_r, p_last_nxt;
  logic                    found_r, found_nxt;
  vtx_t                    cur_r, cur_nxt;
  dist_t                   best_r, best_nxt;
  logic [MAX_VERTICES-1:0] reached_r, reached_nxt;
  logic [MAX_VERTICES-1:0] settled_r, settled_nxt;
  logic [EAW-1:0]          clr_addr_r, clr_addr_nxt;

  logic  out_valid_r, out_valid_nxt;
  logic  out_status_r, out_status_nxt;
  vtx_t  out_vertex_r, out_vertex_nxt;
  dist_t out_distance_r, out_distance_nxt;
  logic  out_reachable_r, out_reachable_nxt;
  logic  out_last_r, out_last_nxt;

  logic [CNT_W-1:0]       n_c;
  logic                   idx_last;
  logic                   slot_free;
  logic                   from_ok, to_ok;
  logic                   scan_cand, sel_found;
  vtx_t                   sel_cur;

  logic                   e_we;
  logic [EAW-1:0]         e_waddr;
  logic [WEIGHT_BITS-1:0] e_wdata;
  logic [EAW-1:0]         e_raddr;
  logic [WEIGHT_BITS-1:0] e_rdata;
  logic                   d_we;
  logic [VB-1:0]          d_waddr;
  dist_t                  d_wdata;
  logic [VB-1:0]          d_raddr;
  dist_t                  d_rdata;
  relax_t                 rlx;

  spd_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(EDEPTH)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  spd_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  spd_relax #(.WEIGHT_BITS(WEIGHT_BITS)) u_relax (
    .base_dist   (best_r),
    .weight      (e_rdata),
    .old_dist    (d_rdata),
    .old_reached (reached_r[VB'(p_idx_r)]),
    .res         (rlx)
  );

  always_comb begin
    n_c       = (vc_r > CNT_W'(CAP)) ? CNT_W'(CAP) : vc_r;
    idx_last  = ({1'b0, idx_r} == (n_c - CNT_W'(1)));
    slot_free = !out_valid_r || !out_stall;
    from_ok   = ({1'b0, from_r} < n_c);
    to_ok     = ({1'b0, to_r} < n_c);
    e_raddr   = {VB'(cur_r), VB'(idx_r)};
    d_raddr   = VB'(idx_r);
    in_stall  = (state_r != ST_IDLE);

    // minimum search over the distance arriving this cycle, lowest index wins ties
    scan_cand = p_vld_r && reached_r[VB'(p_idx_r)] && !settled_r[VB'(p_idx_r)] &&
                (!found_r || (d_rdata < best_r));
    sel_found = found_r || scan_cand;
    sel_cur   = scan_cand ? p_idx_r : cur_r;
  end

  always_comb begin
    state_nxt    = state_r;
    vc_nxt       = cfg_write_en ? cfg_write_data : vc_r;
    op_nxt       = op_r;
    from_nxt     = from_r;
    to_nxt       = to_r;
    wt_nxt       = wt_r;
    err_nxt      = err_r;
    idx_nxt      = idx_r;
    iss_done_nxt = iss_done_r;
    p_vld_nxt    = 1'b0;
    p_idx_nxt    = idx_r;
    p_last_nxt   = idx_last;
    found_nxt    = found_r;
    cur_nxt      = cur_r;
    best_nxt     = best_r;
    reached_nxt  = reached_r;
    settled_nxt  = settled_r;
    clr_addr_nxt = clr_addr_r;

    e_we    = 1'b0;
    e_waddr = {VB'(from_r), VB'(to_r)};
    e_wdata = WEIGHT_BITS'(wt_r);
    d_we    = 1'b0;
    d_waddr = VB'(p_idx_r);
    d_wdata = rlx.new_dist;

    out_valid_nxt     = out_valid_r && out_stall;
    out_status_nxt    = out_status_r;
    out_vertex_nxt    = out_vertex_r;
    out_distance_nxt  = out_distance_r;
    out_reachable_nxt = out_reachable_r;
    out_last_nxt      = out_last_r;

    case (state_r)
      ST_CLEAR: begin
        e_we         = 1'b1;
        e_waddr      = clr_addr_r;
        e_wdata      = '0;
        clr_addr_nxt = clr_addr_r + EAW'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          from_nxt  = in_from_vertex;
          to_nxt    = in_to_vertex;
          wt_nxt    = in_edge_weight;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (op_r)
          OP_WRITE: begin
            err_nxt   = !(from_ok && to_ok);
            e_we      = from_ok && to_ok;
            state_nxt = ST_RESP;
          end
          OP_ONE: begin
            err_nxt   = !(from_ok && to_ok);
            state_nxt = (from_ok && to_ok) ? ST_INIT : ST_RESP;
          end
          OP_ALL: begin
            err_nxt   = !from_ok;
            state_nxt = from_ok ? ST_INIT : ST_RESP;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = err_r;
          out_vertex_nxt    = err_r ? '0 : to_r;
          out_distance_nxt  = '0;
          out_reachable_nxt = 1'b0;
          out_last_nxt      = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_INIT: begin
        reached_nxt                 = '0;
        reached_nxt[VB'(from_r)]    = 1'b1;
        settled_nxt                 = '0;
        d_we                        = 1'b1;
        d_waddr                     = VB'(from_r);
        d_wdata                     = '0;
        idx_nxt                     = '0;
        iss_done_nxt                = 1'b0;
        found_nxt                   = 1'b0;
        state_nxt                   = ST_SCAN;
      end
      ST_SCAN: begin
        if (!iss_done_r) begin
          p_vld_nxt = 1'b1;
          if (idx_last) begin
            iss_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + VTX_W'(1);
          end
        end
        if (scan_cand) begin
          found_nxt = 1'b1;
          cur_nxt   = p_idx_r;
          best_nxt  = d_rdata;
        end
        if (p_vld_r && p_last_r) begin
          iss_done_nxt = 1'b0;
          if (sel_found) begin
            settled_nxt[VB'(sel_cur)] = 1'b1;
            idx_nxt                   = '0;
            state_nxt                 = ST_RELAX;
          end else begin
            idx_nxt   = (op_r == OP_ONE) ? to_r : '0;
            state_nxt = ST_OUTRD;
          end
        end
      end
      ST_RELAX: begin
        if (!iss_done_r) begin
          p_vld_nxt = 1'b1;
          if (idx_last) begin
            iss_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + VTX_W'(1);
          end
        end
        // write-back lands before any later read of the same entry
        if (p_vld_r && rlx.upd) begin
          d_we                         = 1'b1;
          reached_nxt[VB'(p_idx_r)]    = 1'b1;
        end
        if (p_vld_r && p_last_r) begin
          iss_done_nxt = 1'b0;
          idx_nxt      = '0;
          found_nxt    = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_OUTRD: begin
        state_nxt = ST_OUTLD;
      end
      ST_OUTLD: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = 1'b0;
          out_vertex_nxt    = idx_r;
          out_reachable_nxt = reached_r[VB'(idx_r)];
          out_distance_nxt  = reached_r[VB'(idx_r)] ? d_rdata : '0;
          out_last_nxt      = (op_r == OP_ONE) || idx_last;
          if ((op_r == OP_ONE) || idx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + VTX_W'(1);
            state_nxt = ST_OUTRD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      vc_r        <= CNT_W'(16);
      out_valid_r <= 1'b0;
      p_vld_r     <= 1'b0;
      iss_done_r  <= 1'b0;
      found_r     <= 1'b0;
      reached_r   <= '0;
      settled_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      vc_r        <= vc_nxt;
      out_valid_r <= out_valid_nxt;
      p_vld_r     <= p_vld_nxt;
      iss_done_r  <= iss_done_nxt;
      found_r     <= found_nxt;
      reached_r   <= reached_nxt;
      settled_r   <= settled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r            <= op_nxt;
    from_r          <= from_nxt;
    to_r            <= to_nxt;
    wt_r            <= wt_nxt;
    err_r           <= err_nxt;
    idx_r           <= idx_nxt;
    p_idx_r         <= p_idx_nxt;
    p_last_r        <= p_last_nxt;
    cur_r           <= cur_nxt;
    best_r          <= best_nxt;
    out_status_r    <= out_status_nxt;
    out_vertex_r    <= out_vertex_nxt;
    out_distance_r  <= out_distance_nxt;
    out_reachable_r <= out_reachable_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_vertex    = out_vertex_r;
  assign out_distance  = out_distance_r;
  assign out_reachable = out_reachable_r;
  assign out_last      = out_last_r;

  // a settled vertex always has a finite distance
  `SPD_ASSERT_ALWAYS(a_settled_reached, (settled_r & ~reached_r) == '0)
  // error results carry no path
  `SPD_ASSERT_ALWAYS(a_err_no_path, !(out_valid && out_status && (out_reachable || out_distance != '0)))
  // a relaxation write marks its vertex reached
  `SPD_ASSERT_NEXT(a_relax_marks, (state_r == ST_RELAX) && d_we, reached_r[$past(d_waddr)])

endmodule
`default_nettype wire
